// ===== design/rsl_pkg.sv =====
// Shared types, widths and constants for the radial spotlight luminance block.
// No dependencies; every other design file imports this package.
package rsl_pkg;

  localparam int COORD_W     = 12;
  localparam int LUM_W       = 16;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_IDX_W   = 1;
  localparam int COORD_LIMIT = 4096;
  localparam int LIM_W       = 17;

  // Distance path
  localparam int SQ_W      = 2 * COORD_W;
  localparam int D2_W      = SQ_W + 1;
  localparam int NEAR_D2_W = 15;
  localparam logic [D2_W-1:0] NEAR_LIMIT_SQ = 25'd25600;

  // Square root: Q8.8 distance from a radicand of d2 * 2^16
  localparam int ROOT_W      = 16;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int RAD_FRAC_W  = 16;
  localparam int REM_W       = ROOT_W + 3;
  localparam int SQRT_STAGES = 4;
  localparam int SQRT_STEPS  = ROOT_W / SQRT_STAGES;

  // Scaling: lum * factor / 51200, with 51200 = 2^11 * 25
  localparam int FACTOR_W     = 16;
  localparam int PROD_W       = LUM_W + FACTOR_W;
  localparam int DIV_SHIFT    = 11;
  localparam int Q_W          = PROD_W - DIV_SHIFT;
  localparam int RECIP_W      = 17;
  localparam int RECIP_SHIFT  = 21;
  localparam int QM_W         = Q_W + RECIP_W;
  localparam int RES_W        = 6;
  localparam logic [FACTOR_W-1:0] SCALE_Q8   = 16'd51200;
  localparam logic [FACTOR_W-1:0] FAR_FACTOR = 16'd10240;
  localparam logic [RECIP_W-1:0]  RECIP_25   = 17'd83886;
  localparam logic [Q_W-1:0]      DIVISOR_Q  = 21'd25;
  localparam logic [RES_W-1:0]    DIVISOR_R  = 6'd25;
  localparam logic [RES_W-1:0]    RESID_MAX  = 6'd50;

  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [LUM_W-1:0]      lum_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_CENTER_X = 1'b0;
  localparam cfg_idx_t CFG_CENTER_Y = 1'b1;

  typedef struct packed {
    logic   valid;
    coord_t px;
    coord_t py;
    lum_t   lum;
  } pix_item_t;

  typedef struct packed {
    logic                 valid;
    logic                 far;
    logic [NEAR_D2_W-1:0] d2;
    lum_t                 lum;
  } dist_item_t;

  typedef struct packed {
    logic              valid;
    logic              far;
    logic [ROOT_W-1:0] root;
    lum_t              lum;
  } root_item_t;

  function automatic coord_t clamp_coord(coord_t v);
    coord_t res;
    res = v;
    if (LIM_W'(v) >= LIM_W'(COORD_LIMIT)) res = COORD_W'(COORD_LIMIT - 1);
    return res;
  endfunction

endpackage

// ===== design/rsl_dist.sv =====
// Distance front end: clamp, absolute differences, squares, near/far split.
// Three register stages; depends on rsl_pkg.
module rsl_dist (
  input  logic               clk,
  input  logic               rst_n,
  input  rsl_pkg::coord_t    center_x,
  input  rsl_pkg::coord_t    center_y,
  input  rsl_pkg::pix_item_t up,
  output logic               up_ready,
  output rsl_pkg::dist_item_t down,
  input  logic               down_ready
);
  import rsl_pkg::*;

  logic            v1_r, v2_r, v3_r;
  coord_t          dx1_r, dy1_r;
  lum_t            lum1_r, lum2_r, lum3_r;
  logic [SQ_W-1:0] sqx2_r, sqy2_r;
  logic            far3_r;
  logic [NEAR_D2_W-1:0] d23_r;

  logic rdy1, rdy2, rdy3;
  coord_t px, py, cx, cy, dx_nxt, dy_nxt;
  logic [SQ_W-1:0] sqx_nxt, sqy_nxt;
  logic [D2_W-1:0] sum_w;
  logic            far_nxt;
  logic [NEAR_D2_W-1:0] d2_nxt;

  assign rdy3     = !v3_r || down_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  always_comb begin
    px = clamp_coord(up.px);
    py = clamp_coord(up.py);
    cx = clamp_coord(center_x);
    cy = clamp_coord(center_y);
    dx_nxt  = (px >= cx) ? px - cx : cx - px;
    dy_nxt  = (py >= cy) ? py - cy : cy - py;
    sqx_nxt = SQ_W'(dx1_r) * SQ_W'(dx1_r);
    sqy_nxt = SQ_W'(dy1_r) * SQ_W'(dy1_r);
    sum_w   = D2_W'(sqx2_r) + D2_W'(sqy2_r);
    far_nxt = sum_w > NEAR_LIMIT_SQ;
    d2_nxt  = far_nxt ? '0 : sum_w[NEAR_D2_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dx1_r  <= dx_nxt;
      dy1_r  <= dy_nxt;
      lum1_r <= up.lum;
    end
    if (rdy2) begin
      sqx2_r <= sqx_nxt;
      sqy2_r <= sqy_nxt;
      lum2_r <= lum1_r;
    end
    if (rdy3) begin
      far3_r <= far_nxt;
      d23_r  <= d2_nxt;
      lum3_r <= lum2_r;
    end
  end

  assign down = '{valid: v3_r, far: far3_r, d2: d23_r, lum: lum3_r};

endmodule

// ===== design/rsl_sqrt.sv =====
// Pipelined digit-by-digit square root of d2 * 2^16, four result bits per stage.
// Depends on rsl_pkg.
module rsl_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  rsl_pkg::dist_item_t up,
  output logic                up_ready,
  output rsl_pkg::root_item_t down,
  input  logic                down_ready
);
  import rsl_pkg::*;

  logic                 v_r    [SQRT_STAGES];
  logic                 far_r  [SQRT_STAGES];
  logic [NEAR_D2_W-1:0] d2_r   [SQRT_STAGES];
  lum_t                 lum_r  [SQRT_STAGES];
  logic [REM_W-1:0]     rem_r  [SQRT_STAGES];
  logic [ROOT_W-1:0]    root_r [SQRT_STAGES];

  logic                 rdy      [SQRT_STAGES+1];
  logic                 v_nxt    [SQRT_STAGES];
  logic                 far_nxt  [SQRT_STAGES];
  logic [NEAR_D2_W-1:0] d2_nxt   [SQRT_STAGES];
  lum_t                 lum_nxt  [SQRT_STAGES];
  logic [REM_W-1:0]     rem_nxt  [SQRT_STAGES];
  logic [ROOT_W-1:0]    root_nxt [SQRT_STAGES];

  always_comb begin
    logic [REM_W-1:0]  rem_w;
    logic [ROOT_W-1:0] root_w;
    logic [RAD_W-1:0]  rad_w;
    logic [REM_W-1:0]  trial_w;
    rdy[SQRT_STAGES] = down_ready;
    for (int k = SQRT_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (k == 0) begin
        rem_w      = '0;
        root_w     = '0;
        v_nxt[k]   = up.valid;
        far_nxt[k] = up.far;
        d2_nxt[k]  = up.d2;
        lum_nxt[k] = up.lum;
      end else begin
        rem_w      = rem_r[k-1];
        root_w     = root_r[k-1];
        v_nxt[k]   = v_r[k-1];
        far_nxt[k] = far_r[k-1];
        d2_nxt[k]  = d2_r[k-1];
        lum_nxt[k] = lum_r[k-1];
      end
      rad_w = {1'b0, d2_nxt[k], {RAD_FRAC_W{1'b0}}};
      for (int j = 0; j < SQRT_STEPS; j++) begin
        // bring down the next pair of radicand bits, then try a one bit
        rem_w   = {rem_w[REM_W-3:0], rad_w[RAD_W-1-2*(k*SQRT_STEPS+j) -: 2]};
        trial_w = {1'b0, root_w, 2'b01};
        if (rem_w >= trial_w) begin
          rem_w  = rem_w - trial_w;
          root_w = {root_w[ROOT_W-2:0], 1'b1};
        end else begin
          root_w = {root_w[ROOT_W-2:0], 1'b0};
        end
      end
      rem_nxt[k]  = rem_w;
      root_nxt[k] = root_w;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (rdy[k]) begin
        far_r[k]  <= far_nxt[k];
        d2_r[k]   <= d2_nxt[k];
        lum_r[k]  <= lum_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign up_ready = rdy[0];
  assign down = '{valid: v_r[SQRT_STAGES-1], far: far_r[SQRT_STAGES-1],
                  root: root_r[SQRT_STAGES-1], lum: lum_r[SQRT_STAGES-1]};

  // root^2 + remainder must rebuild the radicand exactly
  a_root_exact: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[SQRT_STAGES-1] |->
      (33'(root_r[SQRT_STAGES-1]) * 33'(root_r[SQRT_STAGES-1])
       + 33'(rem_r[SQRT_STAGES-1]))
      == 33'({1'b0, d2_r[SQRT_STAGES-1], {RAD_FRAC_W{1'b0}}}))
    else $error("square root result does not match radicand");

endmodule

// ===== design/rsl_scale.sv =====
// Factor selection, luminance product and division by 51200 via reciprocal.
// Four register stages, the last is the output register; depends on rsl_pkg.
module rsl_scale (
  input  logic                clk,
  input  logic                rst_n,
  input  rsl_pkg::root_item_t up,
  output logic                up_ready,
  output logic                out_valid,
  output rsl_pkg::lum_t       out_lum,
  input  logic                out_stall
);
  import rsl_pkg::*;

  logic              v1_r, v2_r, v3_r, out_valid_r;
  logic [PROD_W-1:0] prod1_r;
  lum_t              lum1_r, lum2_r, lum3_r, lum4_r;
  logic [QM_W-1:0]   qm2_r;
  logic [Q_W-1:0]    q2_r;
  lum_t              quo3_r;
  logic [RES_W-1:0]  res3_r;
  lum_t              out_lum_r;

  logic rdy1, rdy2, rdy3, rdy4;
  logic [FACTOR_W-1:0] root_lim, factor;
  logic [PROD_W-1:0]   prod_nxt;
  logic [Q_W-1:0]      q_nxt;
  logic [QM_W-1:0]     qm_nxt;
  logic [QM_W-RECIP_SHIFT-1:0] quo_w;
  logic [Q_W-1:0]      res_w;
  lum_t                out_lum_nxt;

  assign rdy4     = !out_valid_r || !out_stall;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  always_comb begin
    // far pixels: factor 0.2 is 10240 / 51200
    root_lim = (up.root > SCALE_Q8) ? SCALE_Q8 : up.root;
    factor   = up.far ? FAR_FACTOR : SCALE_Q8 - root_lim;
    prod_nxt = PROD_W'(up.lum) * PROD_W'(factor);
    q_nxt    = prod1_r[PROD_W-1 -: Q_W];
    qm_nxt   = QM_W'(q_nxt) * QM_W'(RECIP_25);
    // estimate is low by at most one, so the residue stays below 50
    quo_w    = qm2_r[QM_W-1:RECIP_SHIFT];
    res_w    = q2_r - Q_W'(quo_w) * DIVISOR_Q;
    out_lum_nxt = (res3_r >= DIVISOR_R) ? quo3_r + 1'b1 : quo3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r        <= up.valid;
      if (rdy2) v2_r        <= v1_r;
      if (rdy3) v3_r        <= v2_r;
      if (rdy4) out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      prod1_r <= prod_nxt;
      lum1_r  <= up.lum;
    end
    if (rdy2) begin
      qm2_r  <= qm_nxt;
      q2_r   <= q_nxt;
      lum2_r <= lum1_r;
    end
    if (rdy3) begin
      quo3_r <= quo_w[LUM_W-1:0];
      res3_r <= res_w[RES_W-1:0];
      lum3_r <= lum2_r;
    end
    if (rdy4) begin
      out_lum_r <= out_lum_nxt;
      lum4_r    <= lum3_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_lum   = out_lum_r;

  a_resid_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> res3_r < RESID_MAX)
    else $error("reciprocal quotient estimate off by more than one");

  a_no_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_lum_r <= lum4_r)
    else $error("dimmed luminance exceeds input luminance");

endmodule

// ===== design/radial_spotlight_luminance.sv =====
// Register stages from input acceptance to out_valid: 3 distance, 4 root, 4 scale.
// Throughput: one transaction per cycle while out_stall is low; every stage is a register with its own valid bit.
// The 16-bit square root, four result bits per stage, and the two multiplies set the depth.
// Back-pressure ripples stage by stage, so bubbles are squeezed out while out_stall is high.
// Synchronous active-low reset clears all valid bits and sets both centre registers to 0.
module radial_spotlight_luminance (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rsl_pkg::coord_t     in_pixel_x,
  input  rsl_pkg::coord_t     in_pixel_y,
  input  rsl_pkg::lum_t       in_lum_in,
  output logic                out_valid,
  input  logic                out_stall,
  output rsl_pkg::lum_t       out_lum_out,
  input  logic                cfg_we,
  input  rsl_pkg::cfg_idx_t   cfg_index,
  input  rsl_pkg::cfg_data_t  cfg_wdata
);
  import rsl_pkg::*;

  // Spotlight centre; the user must write it only while the pipeline is empty (not enforced).
  coord_t center_x_r, center_y_r;
  coord_t center_x_nxt, center_y_nxt;

  pix_item_t  pix_item;
  dist_item_t dist_item;
  root_item_t root_item;
  logic       dist_ready, sqrt_ready, scale_ready;

  always_comb begin
    center_x_nxt = center_x_r;
    center_y_nxt = center_y_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_X: center_x_nxt = cfg_wdata[COORD_W-1:0];
        CFG_CENTER_Y: center_y_nxt = cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
    end else begin
      center_x_r <= center_x_nxt;
      center_y_r <= center_y_nxt;
    end
  end

  // Hand the incoming transaction to the distance stages.
  assign pix_item = '{valid: in_valid, px: in_pixel_x, py: in_pixel_y, lum: in_lum_in};
  // Hold the source whenever the first stage cannot advance.
  assign in_stall = !dist_ready;

  rsl_dist u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .center_x   (center_x_r),
    .center_y   (center_y_r),
    .up         (pix_item),
    .up_ready   (dist_ready),
    .down       (dist_item),
    .down_ready (sqrt_ready)
  );

  // Far pixels still flow through the root stages; their root is ignored.
  rsl_sqrt u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .up         (dist_item),
    .up_ready   (sqrt_ready),
    .down       (root_item),
    .down_ready (scale_ready)
  );

  rsl_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .up        (root_item),
    .up_ready  (scale_ready),
    .out_valid (out_valid),
    .out_lum   (out_lum_out),
    .out_stall (out_stall)
  );

  // An empty output register must never push back on the source.
  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register is empty");

endmodule
